@@ rtl/wlc_pkg.sv @@
// shared constants, codes and controller/datapath interface types
// for the weighted least-connections selector; no dependencies
package wlc_pkg;

  localparam int NODES      = 8;
  localparam int COUNT_BITS = 16;
  localparam int WIDE_SLOTS = 8;
  localparam int SLOTS      = (NODES < WIDE_SLOTS) ? NODES : WIDE_SLOTS;
  localparam int PROD_W     = COUNT_BITS + 8;

  localparam logic [15:0] TIE_SEED = 16'hACE1;
  localparam logic [15:0] TIE_TAPS = 16'hB400;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  localparam logic [3:0]  NODE_COUNT_RST   = 4'd1;
  localparam logic [63:0] NODE_WEIGHTS_RST = 64'h1010_1010_1010_1010;

  typedef enum logic [1:0] {
    ACT_ACQUIRE = 2'd0,
    ACT_RELEASE = 2'd1,
    ACT_STATUS  = 2'd2,
    ACT_NONE    = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    OUT_DONE        = 2'd0,
    OUT_NO_ELIGIBLE = 2'd1,
    OUT_BAD_INDEX   = 2'd2,
    OUT_UNUSED      = 2'd3
  } outcome_t;

  typedef enum logic {
    CFG_NODE_COUNT   = 1'b0,
    CFG_NODE_WEIGHTS = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic modulo;
    logic apply;
  } dp_cmd_t;

  typedef struct packed {
    logic is_acquire;
    logic step_last;
    logic out_free;
  } dp_status_t;

endpackage

@@ rtl/wlc_ctrl.sv @@
// sequencing state machine for the selector
// depends on wlc_pkg; drives wlc_datapath through dp_cmd_t
module wlc_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  wlc_pkg::dp_status_t status,
  output wlc_pkg::dp_cmd_t   cmd
);
  import wlc_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_MOD   = 4'b0100,
    ST_APPLY = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = status.is_acquire ? ST_SCAN : ST_APPLY;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (status.step_last) begin
          state_nxt = ST_MOD;
        end
      end
      ST_MOD: begin
        cmd.modulo = 1'b1;
        if (status.step_last) begin
          state_nxt = ST_APPLY;
        end
      end
      ST_APPLY: begin
        cmd.apply = 1'b1;
        if (status.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ rtl/wlc_datapath.sv @@
// node table, ratio compare, tie modulo, tie pick and result register
// depends on wlc_pkg; sequenced by wlc_ctrl
module wlc_datapath (
  input  logic               clk,
  input  logic               rst_n,
  input  wlc_pkg::dp_cmd_t   cmd,
  output wlc_pkg::dp_status_t status,
  input  logic [1:0]         in_action,
  input  logic [2:0]         in_node_index,
  input  logic [7:0]         in_exclude_mask,
  input  logic               in_online,
  input  logic               cfg_wr_en,
  input  logic               cfg_index,
  input  logic [63:0]        cfg_wdata,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         out_chosen_node,
  output logic [1:0]         out_outcome
);
  import wlc_pkg::*;

  logic [COUNT_BITS-1:0] counts_r [WIDE_SLOTS];
  logic [WIDE_SLOTS-1:0] up_r;
  logic [15:0]           lfsr_r;
  logic [3:0]            node_count_r;
  logic [63:0]           weights_r;
  logic [2:0]            step_r;
  logic [3:0]            tie_cnt_r;
  logic [WIDE_SLOTS-1:0] tie_mask_r;
  logic                  out_valid_r;

  action_t               act_r;
  logic [2:0]            idx_r;
  logic [7:0]            mask_r;
  logic                  online_r;
  logic [COUNT_BITS-1:0] best_cnt_r;
  logic [7:0]            best_w_r;
  logic [15:0]           div_sh_r;
  logic [2:0]            rem_r;
  logic [2:0]            chosen_r;
  outcome_t              outcome_r;

  logic [15:0]           lfsr_nxt;
  logic [2:0]            rem_nxt;
  logic [3:0]            n_eff;
  logic [2:0]            rd_idx;
  logic [COUNT_BITS-1:0] rd_cnt;
  logic [7:0]            w_sel;
  logic                  elig;
  logic [PROD_W-1:0]     lhs;
  logic [PROD_W-1:0]     rhs;
  logic                  take_new;
  logic                  take_tie;
  logic [4:0]            t0, t1, t2, twoc;
  logic [2:0]            pick;
  logic                  out_free;
  logic                  commit;
  logic                  in_use;
  logic [2:0]            chosen_nxt;
  outcome_t              outcome_nxt;
  logic                  cnt_wr;
  logic [COUNT_BITS-1:0] cnt_val;
  logic                  up_wr;

  assign lfsr_nxt = lfsr_r[0] ? ((lfsr_r >> 1) ^ TIE_TAPS) : (lfsr_r >> 1);
  assign n_eff    = (node_count_r > 4'(SLOTS)) ? 4'(SLOTS) : node_count_r;
  assign out_free = !out_valid_r || out_ready;
  assign commit   = cmd.apply && out_free;

  // single read port on the count table
  assign rd_idx = cmd.scan ? step_r : ((act_r == ACT_ACQUIRE) ? pick : idx_r);
  assign rd_cnt = counts_r[rd_idx];
  assign w_sel  = weights_r[8*step_r +: 8];

  // ratio compare by cross-multiplication
  assign elig = ({1'b0, step_r} < n_eff) && up_r[step_r] && !mask_r[step_r] &&
                (w_sel != 8'd0);
  assign lhs  = PROD_W'(best_cnt_r) * PROD_W'(w_sel);
  assign rhs  = PROD_W'(rd_cnt) * PROD_W'(best_w_r);
  assign take_new = cmd.scan && elig && ((tie_cnt_r == 4'd0) || (lhs > rhs));
  assign take_tie = cmd.scan && elig && (tie_cnt_r != 4'd0) && (lhs == rhs);

  // two remainder bits per step
  assign twoc    = {tie_cnt_r, 1'b0};
  assign t0      = {rem_r, div_sh_r[15:14]};
  assign t1      = (t0 >= twoc) ? (t0 - twoc) : t0;
  assign t2      = (t1 >= {1'b0, tie_cnt_r}) ? (t1 - {1'b0, tie_cnt_r}) : t1;
  assign rem_nxt = t2[2:0];

  // position rem_r among the tied nodes
  always_comb begin
    logic [3:0] seen;
    pick = '0;
    seen = '0;
    for (int i = 0; i < WIDE_SLOTS; i++) begin
      if (tie_mask_r[i]) begin
        if (seen == {1'b0, rem_r}) begin
          pick = 3'(i);
        end
        seen = seen + 4'd1;
      end
    end
  end

  assign in_use = ({1'b0, idx_r} < n_eff);

  always_comb begin
    chosen_nxt  = '0;
    outcome_nxt = OUT_DONE;
    cnt_wr      = 1'b0;
    cnt_val     = rd_cnt;
    up_wr       = 1'b0;
    unique case (act_r)
      ACT_ACQUIRE: begin
        if (tie_cnt_r == 4'd0) begin
          outcome_nxt = OUT_NO_ELIGIBLE;
        end else begin
          chosen_nxt = pick;
          cnt_wr     = 1'b1;
          cnt_val    = (rd_cnt == COUNT_MAX) ? rd_cnt : rd_cnt + 1'b1;
        end
      end
      ACT_RELEASE: begin
        if (!in_use) begin
          outcome_nxt = OUT_BAD_INDEX;
        end else begin
          cnt_wr  = 1'b1;
          cnt_val = (rd_cnt == '0) ? rd_cnt : rd_cnt - 1'b1;
        end
      end
      ACT_STATUS: begin
        if (!in_use) begin
          outcome_nxt = OUT_BAD_INDEX;
        end else begin
          up_wr = 1'b1;
        end
      end
      default: begin
        outcome_nxt = OUT_DONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < WIDE_SLOTS; i++) begin
        counts_r[i] <= '0;
      end
      up_r         <= '1;
      lfsr_r       <= TIE_SEED;
      node_count_r <= NODE_COUNT_RST;
      weights_r    <= NODE_WEIGHTS_RST;
      step_r       <= '0;
      tie_cnt_r    <= '0;
      tie_mask_r   <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_reg_t'(cfg_index))
          CFG_NODE_COUNT:   node_count_r <= cfg_wdata[3:0];
          CFG_NODE_WEIGHTS: weights_r    <= cfg_wdata;
          default:          node_count_r <= node_count_r;
        endcase
      end
      if (cmd.load) begin
        step_r     <= '0;
        tie_cnt_r  <= '0;
        tie_mask_r <= '0;
        if (status.is_acquire) begin
          lfsr_r <= lfsr_nxt;
        end
      end else if (cmd.scan || cmd.modulo) begin
        step_r <= step_r + 3'd1;
      end
      if (take_new) begin
        tie_cnt_r  <= 4'd1;
        tie_mask_r <= WIDE_SLOTS'(1) << step_r;
      end else if (take_tie) begin
        tie_cnt_r  <= tie_cnt_r + 4'd1;
        tie_mask_r <= tie_mask_r | (WIDE_SLOTS'(1) << step_r);
      end
      if (commit && cnt_wr) begin
        counts_r[rd_idx] <= cnt_val;
      end
      if (commit && up_wr) begin
        up_r[idx_r] <= online_r;
      end
      if (commit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r    <= action_t'(in_action);
      idx_r    <= in_node_index;
      mask_r   <= in_exclude_mask;
      online_r <= in_online;
      div_sh_r <= lfsr_nxt;
      rem_r    <= '0;
    end else if (cmd.modulo) begin
      div_sh_r <= div_sh_r << 2;
      rem_r    <= rem_nxt;
    end
    if (take_new) begin
      best_cnt_r <= rd_cnt;
      best_w_r   <= w_sel;
    end
    if (commit) begin
      chosen_r  <= chosen_nxt;
      outcome_r <= outcome_nxt;
    end
  end

  assign status.is_acquire = (action_t'(in_action) == ACT_ACQUIRE);
  assign status.step_last  = (step_r == 3'd7);
  assign status.out_free   = out_free;

  assign out_valid       = out_valid_r;
  assign out_chosen_node = chosen_r;
  assign out_outcome     = outcome_r;

  a_tie_count: assert property (@(posedge clk) disable iff (!rst_n)
    tie_cnt_r == 4'($countones(tie_mask_r)))
    else $error("tie count out of step with tie mask");

  a_lfsr_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    lfsr_r != 16'd0)
    else $error("tie lfsr reached zero");

  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    commit && (act_r == ACT_ACQUIRE) && (tie_cnt_r != 4'd0) |->
      ({1'b0, rem_r} < tie_cnt_r))
    else $error("tie remainder not below tie count");

  a_pick_tied: assert property (@(posedge clk) disable iff (!rst_n)
    commit && (act_r == ACT_ACQUIRE) && (tie_cnt_r != 4'd0) |-> tie_mask_r[pick])
    else $error("granted node is not among the tied nodes");

endmodule

@@ rtl/weighted_least_conn_selector.sv @@
// top level of the weighted least-connections selector
// depends on wlc_pkg, wlc_ctrl and wlc_datapath
//
//   port group   dir  handshake            contents
//   in_*         in   in_valid/in_ready    action, node_index, exclude_mask, online
//   out_*        out  out_valid/out_ready  chosen_node, outcome
//   cfg_*        in   cfg_wr_en            index 0 node_count, 1 node_weights
//
// acquire: load, then one node per cycle over 8 scan steps
// with one ratio compare, then 8 steps of the two-bit tie modulo, then one write
// release, status and unused actions: load, then the write
// the next request is taken while a result waits; only the final write stalls
// on out_ready; synchronous active-low reset, no clearing pass
module weighted_least_conn_selector (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_action,
  input  logic [2:0]  in_node_index,
  input  logic [7:0]  in_exclude_mask,
  input  logic        in_online,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_chosen_node,
  output logic [1:0]  out_outcome,
  input  logic        cfg_wr_en,
  input  logic        cfg_index,
  input  logic [63:0] cfg_wdata
);
  import wlc_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  wlc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  wlc_datapath u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .status          (status),
    .in_action       (in_action),
    .in_node_index   (in_node_index),
    .in_exclude_mask (in_exclude_mask),
    .in_online       (in_online),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_chosen_node (out_chosen_node),
    .out_outcome     (out_outcome)
  );

endmodule
